/* src/apbmon_pkg.sv */
// Package for the APB protocol monitor: bus phase encoding, sample and
// result flag structs, and default constants.
// No dependencies.
package apbmon_pkg;

    // Default widths of the monitored bus
    localparam int unsigned ADDR_WIDTH_DEF = 32;
    localparam int unsigned DATA_WIDTH_DEF = 32;

    // Timeout limit register
    localparam int unsigned TIMEOUT_WIDTH = 16;
    localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 16'd100;
    localparam logic [TIMEOUT_WIDTH-1:0] ACCESS_CNT_MAX = '1;

    // APB transfer phase
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SETUP  = 2'd1,
        PH_ACCESS = 2'd2
    } phase_t;

    // Single-bit bus signals of one sample
    typedef struct packed {
        logic reset_n;
        logic select;
        logic enable;
        logic write_dir;
        logic ready_req;
        logic slave_err;
    } ctrl_t;

    // Per-sample check results
    typedef struct packed {
        logic err_reset_abort;
        logic err_addr_unstable_setup;
        logic err_addr_unstable_access;
        logic err_data_unstable;
        logic err_drop_setup;
        logic err_drop_access;
        logic err_slave;
        logic err_timeout;
        logic transfer_done;
    } flags_t;

endpackage

/* src/apbmon_check.sv */
// APB monitor check core: phase tracking, latched transfer state and the
// per-sample protocol checks. Updates its state once per advanced sample.
// Depends on apbmon_pkg.
module apbmon_check #(
    parameter int unsigned ADDR_WIDTH = apbmon_pkg::ADDR_WIDTH_DEF,
    parameter int unsigned DATA_WIDTH = apbmon_pkg::DATA_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  step,
    input  apbmon_pkg::ctrl_t                     ctrl,
    input  logic [ADDR_WIDTH-1:0]                 addr,
    input  logic [DATA_WIDTH-1:0]                 wdata,
    input  logic [apbmon_pkg::TIMEOUT_WIDTH-1:0]  limit,
    output apbmon_pkg::flags_t                    flags,
    output apbmon_pkg::phase_t                    phase_next,
    output logic [ADDR_WIDTH-1:0]                 addr_next
);
    import apbmon_pkg::*;

    phase_t                   phase_reg;
    logic [ADDR_WIDTH-1:0]    held_addr_reg;
    logic [DATA_WIDTH-1:0]    held_data_reg, held_data_next;
    logic                     data_held_reg, data_held_next;
    logic [TIMEOUT_WIDTH-1:0] acc_cnt_reg, acc_cnt_next;
    logic [TIMEOUT_WIDTH-1:0] acc_cnt_inc;
    logic                     addr_diff;
    logic                     data_diff;

    assign acc_cnt_inc = (acc_cnt_reg == ACCESS_CNT_MAX) ? acc_cnt_reg
                                                         : acc_cnt_reg + 1'b1;
    assign addr_diff   = (addr != held_addr_reg);
    assign data_diff   = ctrl.write_dir && data_held_reg && (wdata != held_data_reg);

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (!ctrl.reset_n) begin
            phase_next = PH_IDLE;
        end else begin
            case (phase_reg)
                PH_IDLE: begin
                    if (ctrl.select && !ctrl.enable) phase_next = PH_SETUP;
                end
                PH_SETUP: begin
                    if (ctrl.select && ctrl.enable) phase_next = PH_ACCESS;
                    else if (!ctrl.select)          phase_next = PH_IDLE;
                end
                PH_ACCESS: begin
                    if (ctrl.ready_req || !ctrl.select || !ctrl.enable ||
                        (acc_cnt_inc > limit)) begin
                        phase_next = PH_IDLE;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // Check flags
    always_comb begin
        flags = '0;
        if (!ctrl.reset_n) begin
            flags.err_reset_abort = (phase_reg != PH_IDLE);
            flags.transfer_done   = (phase_reg != PH_IDLE);
        end else begin
            case (phase_reg)
                PH_IDLE: ;
                PH_SETUP: begin
                    flags.err_addr_unstable_setup = addr_diff;
                    if (!ctrl.enable || !ctrl.select) begin
                        flags.err_drop_setup = !ctrl.select;
                        flags.transfer_done  = !ctrl.select;
                    end
                end
                PH_ACCESS: begin
                    flags.err_addr_unstable_access = addr_diff;
                    flags.err_data_unstable        = data_diff;
                    if (ctrl.ready_req) begin
                        flags.err_slave     = ctrl.slave_err;
                        flags.transfer_done = 1'b1;
                    end else if (!ctrl.select || !ctrl.enable) begin
                        flags.err_drop_access = 1'b1;
                        flags.transfer_done   = 1'b1;
                    end else if (acc_cnt_inc > limit) begin
                        flags.err_timeout   = 1'b1;
                        flags.transfer_done = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Latched transfer state
    always_comb begin
        addr_next      = held_addr_reg;
        held_data_next = held_data_reg;
        data_held_next = data_held_reg;
        acc_cnt_next   = acc_cnt_reg;
        if (ctrl.reset_n && phase_reg == PH_IDLE && ctrl.select && !ctrl.enable) begin
            addr_next      = addr;
            data_held_next = ctrl.write_dir;
            if (ctrl.write_dir) held_data_next = wdata;
        end
        if (ctrl.reset_n && phase_reg == PH_ACCESS) acc_cnt_next = acc_cnt_inc;
        if (ctrl.reset_n && phase_reg == PH_SETUP && phase_next == PH_ACCESS) begin
            acc_cnt_next = TIMEOUT_WIDTH'(1);
        end
        if (phase_next == PH_IDLE) begin
            data_held_next = 1'b0;
            acc_cnt_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            held_addr_reg <= '0;
            held_data_reg <= '0;
            data_held_reg <= 1'b0;
            acc_cnt_reg   <= '0;
        end else if (step) begin
            phase_reg     <= phase_next;
            held_addr_reg <= addr_next;
            held_data_reg <= held_data_next;
            data_held_reg <= data_held_next;
            acc_cnt_reg   <= acc_cnt_next;
        end
    end

endmodule

/* src/apb_protocol_monitor_core.sv */
// Top level of the APB protocol monitor: sample input register, check core,
// result register and the timeout limit register.
// Depends on apbmon_pkg and apbmon_check.
//
// Passive APB checker. Each transaction on the s_ channel is one sample of the
// bus (one PCLK); each produces exactly one result transaction on the m_
// channel carrying the error flags, transfer_done, the phase after the sample
// and the latched transfer address. One sample is taken per cycle unless a
// full result register waits on m_ready; a sample goes through the sample
// register, then the result register, with a single short pass of check
// logic between them. The timeout limit (reset 100) is written through the
// cfg_ channel while the monitor is idle, a rule for the user the block does
// not enforce; a timeout fires on the limit-th ACCESS sample without PREADY.
module apb_protocol_monitor_core #(
    parameter int unsigned ADDR_WIDTH = apbmon_pkg::ADDR_WIDTH_DEF,
    parameter int unsigned DATA_WIDTH = apbmon_pkg::DATA_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // timeout limit register write
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [apbmon_pkg::TIMEOUT_WIDTH-1:0]  cfg_data,
    // bus samples
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_reset_n,
    input  logic                                  s_select,
    input  logic                                  s_enable,
    input  logic                                  s_write_dir,
    input  logic                                  s_ready_req,
    input  logic                                  s_slave_err,
    input  logic [ADDR_WIDTH-1:0]                 s_address,
    input  logic [DATA_WIDTH-1:0]                 s_write_data,
    // check results
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_err_reset_abort,
    output logic                                  m_err_addr_unstable_setup,
    output logic                                  m_err_addr_unstable_access,
    output logic                                  m_err_data_unstable,
    output logic                                  m_err_drop_setup,
    output logic                                  m_err_drop_access,
    output logic                                  m_err_slave,
    output logic                                  m_err_timeout,
    output logic                                  m_transfer_done,
    output logic [1:0]                            m_phase,
    output logic [ADDR_WIDTH-1:0]                 m_report_address
);
    import apbmon_pkg::*;

    logic [TIMEOUT_WIDTH-1:0] limit_reg;
    logic                     in_valid_reg;
    ctrl_t                    in_ctrl_reg;
    logic [ADDR_WIDTH-1:0]    in_addr_reg;
    logic [DATA_WIDTH-1:0]    in_data_reg;
    logic                     out_valid_reg;
    flags_t                   out_flags_reg;
    phase_t                   out_phase_reg;
    logic [ADDR_WIDTH-1:0]    out_addr_reg;
    logic                     advance;
    flags_t                   flags;
    phase_t                   phase_next;
    logic [ADDR_WIDTH-1:0]    addr_next;

    // Limit register, always writable
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= TIMEOUT_RESET;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    // Sample moves to the result register when that slot is free or drains
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Sample register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_ctrl_reg <= '{reset_n:   s_reset_n,
                             select:    s_select,
                             enable:    s_enable,
                             write_dir: s_write_dir,
                             ready_req: s_ready_req,
                             slave_err: s_slave_err};
            in_addr_reg <= s_address;
            in_data_reg <= s_write_data;
        end
    end

    apbmon_check #(
        .ADDR_WIDTH(ADDR_WIDTH),
        .DATA_WIDTH(DATA_WIDTH)
    ) u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .ctrl       (in_ctrl_reg),
        .addr       (in_addr_reg),
        .wdata      (in_data_reg),
        .limit      (limit_reg),
        .flags      (flags),
        .phase_next (phase_next),
        .addr_next  (addr_next)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_flags_reg <= flags;
            out_phase_reg <= phase_next;
            out_addr_reg  <= addr_next;
        end
    end

    assign m_valid                    = out_valid_reg;
    assign m_err_reset_abort          = out_flags_reg.err_reset_abort;
    assign m_err_addr_unstable_setup  = out_flags_reg.err_addr_unstable_setup;
    assign m_err_addr_unstable_access = out_flags_reg.err_addr_unstable_access;
    assign m_err_data_unstable        = out_flags_reg.err_data_unstable;
    assign m_err_drop_setup           = out_flags_reg.err_drop_setup;
    assign m_err_drop_access          = out_flags_reg.err_drop_access;
    assign m_err_slave                = out_flags_reg.err_slave;
    assign m_err_timeout              = out_flags_reg.err_timeout;
    assign m_transfer_done            = out_flags_reg.transfer_done;
    assign m_phase                    = 2'(out_phase_reg);
    assign m_report_address           = out_addr_reg;

    // A reset abort always closes a transfer
    a_abort_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_err_reset_abort) |-> m_transfer_done)
        else $error("reset abort without transfer_done");

    // Terminating errors always close a transfer
    a_term_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_err_drop_setup || m_err_drop_access ||
                     m_err_timeout || m_err_slave)) |-> m_transfer_done)
        else $error("terminating error without transfer_done");

    // A finished transfer leaves the bus idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_transfer_done) |-> (m_phase == 2'(PH_IDLE)))
        else $error("transfer_done with phase not idle");

endmodule
